// File: design/mdlt_pkg.sv
// Shared types and constants for the MAC deny-list table.
`default_nettype none
package mdlt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int MAC_W   = 48;
  localparam int ECNT_W  = 5;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [MAC_W-1:0]  station_mac;
  } req_item_t;

  typedef struct packed {
    logic              denied;
    status_t           status;
    logic [ECNT_W-1:0] entry_count;
  } rsp_item_t;

endpackage
`default_nettype wire

// File: design/mac_deny_list_table.sv
// Top level of the MAC deny-list table: operation sequencer around the address RAM.
//
// Each item is one operation (check, add, delete, clear) on a 48-bit station
// address and yields exactly one result item with the denied flag, a status
// code and the entry count after the operation. An item is not accepted until
// the previous one has been written back: the addresses sit in a RAM with one
// read port, so the lookup walks every slot through the registered read port,
// finding both the matching entry and the lowest free slot on the way, then
// writes back and issues the result in S_FINISH, which waits while an earlier
// result is still stalled on the output. A new item is taken the cycle after
// the previous one has been written back; the result register lets that happen
// while the previous result still waits on the output. Valid marks are
// flip-flops cleared at reset, so no clearing pass is needed after reset.
`default_nettype none
module mac_deny_list_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mdlt_pkg::req_item_t req,
  input  wire logic               req_valid,
  output logic                    req_stall,
  output mdlt_pkg::rsp_item_t     rsp,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state;
  mdlt_pkg::opcode_t               op;
  logic [mdlt_pkg::MAC_W-1:0]      mac;
  logic [mdlt_pkg::CNT_W-1:0]      rd_cnt;
  logic                            cmp_vld;
  logic [mdlt_pkg::IDX_W-1:0]      cmp_idx;
  logic                            hit_found;
  logic [mdlt_pkg::IDX_W-1:0]      hit_idx;
  logic                            free_found;
  logic [mdlt_pkg::IDX_W-1:0]      free_idx;
  logic [mdlt_pkg::ENTRIES-1:0]    valid;
  logic [mdlt_pkg::CNT_W-1:0]      count;

  logic                            rd_en;
  logic [mdlt_pkg::IDX_W-1:0]      rd_addr;
  logic [mdlt_pkg::MAC_W-1:0]      rd_data;
  logic                            wr_en;
  logic                            finish_go;
  logic                            cmp_hit;
  logic                            cmp_free;
  logic                            cmp_last;

  logic [mdlt_pkg::CNT_W-1:0]      count_next;
  logic [mdlt_pkg::ENTRIES-1:0]    valid_next;
  mdlt_pkg::status_t               status_next;
  logic [mdlt_pkg::CNT_W+mdlt_pkg::ECNT_W-1:0] count_ext;

  assign req_stall = (state != S_IDLE);
  assign rd_en     = (state == S_SCAN) && (rd_cnt < mdlt_pkg::CNT_W'(mdlt_pkg::ENTRIES));
  assign rd_addr   = rd_cnt[mdlt_pkg::IDX_W-1:0];
  assign finish_go = (state == S_FINISH) && !(rsp_valid && rsp_stall);
  assign wr_en     = finish_go && (op == mdlt_pkg::OP_ADD) && !hit_found && free_found;

  assign cmp_hit  = cmp_vld && valid[cmp_idx] && (rd_data == mac);
  assign cmp_free = cmp_vld && !valid[cmp_idx];
  assign cmp_last = cmp_vld && (cmp_idx == mdlt_pkg::IDX_W'(mdlt_pkg::ENTRIES - 1));

  mdlt_ram #(
    .WIDTH (mdlt_pkg::MAC_W),
    .DEPTH (mdlt_pkg::ENTRIES)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (mac),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Work out the table update and status from the scan results.
  always_comb begin
    count_next  = count;
    valid_next  = valid;
    status_next = mdlt_pkg::ST_OK;
    case (op)
      mdlt_pkg::OP_CHECK: begin
        status_next = hit_found ? mdlt_pkg::ST_OK : mdlt_pkg::ST_NOT_FOUND;
      end
      mdlt_pkg::OP_ADD: begin
        if (hit_found) begin
          status_next = mdlt_pkg::ST_PRESENT;
        end else if (!free_found) begin
          status_next = mdlt_pkg::ST_FULL;
        end else begin
          valid_next[free_idx] = 1'b1;
          count_next           = count + mdlt_pkg::CNT_W'(1);
        end
      end
      mdlt_pkg::OP_DELETE: begin
        if (hit_found) begin
          valid_next[hit_idx] = 1'b0;
          if (count != '0) begin
            count_next = count - mdlt_pkg::CNT_W'(1);
          end
        end else begin
          status_next = mdlt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        valid_next = '0;
        count_next = '0;
      end
    endcase
    count_ext = (mdlt_pkg::CNT_W + mdlt_pkg::ECNT_W)'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      valid      <= '0;
      count      <= '0;
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (finish_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req.opcode;
            mac        <= req.station_mac;
            rd_cnt     <= '0;
            cmp_vld    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + mdlt_pkg::CNT_W'(1);
          end
          cmp_vld <= rd_en;
          cmp_idx <= rd_addr;
          // Keep the first match and the lowest free slot.
          if (cmp_hit && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
          end
          if (cmp_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (cmp_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_go) begin
            valid           <= valid_next;
            count           <= count_next;
            rsp.denied      <= hit_found;
            rsp.status      <= status_next;
            rsp.entry_count <= count_ext[mdlt_pkg::ECNT_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/mdlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mdlt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic                                        rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: verif/mdlt_checker.sv
// Response checker for the MAC deny-list table: tracks the table and compares every result.
module mdlt_checker (
  input  logic                clk,
  input  logic                rst,
  input  mdlt_pkg::req_item_t req,
  input  logic                req_valid,
  input  logic                req_stall,
  input  mdlt_pkg::rsp_item_t rsp,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  output int                  errors,
  output int                  verdicts_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [mdlt_pkg::MAC_W-1:0] slot_mac [mdlt_pkg::ENTRIES];
  logic                       slot_live [mdlt_pkg::ENTRIES];
  logic [15:0]                live_total;
  mdlt_pkg::rsp_item_t        pending_verdicts [$];
  int                         rsp_seen;

  initial begin
    errors = 0;
    verdicts_owed = 0;
    rsp_seen = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("checker: %s wrong at result %0d: got %0h, want %0h", what, rsp_seen, got, want);
    errors++;
  endtask

  // Look the address up, apply the operation to the table copy, build the verdict.
  function automatic mdlt_pkg::rsp_item_t apply_table_op(input mdlt_pkg::req_item_t op);
    mdlt_pkg::rsp_item_t verdict;
    int hit;
    int free_slot;
    int i;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < mdlt_pkg::ENTRIES; i++) begin
      if (hit < 0 && slot_live[i] && slot_mac[i] == op.station_mac) hit = i;
      if (free_slot < 0 && !slot_live[i]) free_slot = i;
    end
    verdict.status = mdlt_pkg::ST_OK;
    case (op.opcode)
      mdlt_pkg::OP_CHECK: begin
        if (hit < 0) verdict.status = mdlt_pkg::ST_NOT_FOUND;
      end
      mdlt_pkg::OP_ADD: begin
        if (hit >= 0) begin
          verdict.status = mdlt_pkg::ST_PRESENT;
        end else if (free_slot < 0) begin
          verdict.status = mdlt_pkg::ST_FULL;
        end else begin
          slot_mac[free_slot] = op.station_mac;
          slot_live[free_slot] = 1'b1;
          live_total = live_total + 1'b1;
        end
      end
      mdlt_pkg::OP_DELETE: begin
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          if (live_total > 0) live_total = live_total - 1'b1;
        end else begin
          verdict.status = mdlt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        for (i = 0; i < mdlt_pkg::ENTRIES; i++) slot_live[i] = 1'b0;
        live_total = '0;
      end
    endcase
    // denied reports the state before the operation, clear included
    verdict.denied = (hit >= 0);
    verdict.entry_count = live_total[mdlt_pkg::ECNT_W-1:0];
    return verdict;
  endfunction

  always @(posedge clk) begin : watch
    int delta;
    mdlt_pkg::rsp_item_t want;
    delta = 0;
    if (rst) begin
      for (int i = 0; i < mdlt_pkg::ENTRIES; i++) slot_live[i] = 1'b0;
      live_total = '0;
    end else begin
      if (req_valid && !req_stall) begin
        pending_verdicts.push_back(apply_table_op(req));
        delta++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_verdicts.size() == 0) begin
          report("unexpected result", 64'(rsp), 64'd0);
        end else begin
          want = pending_verdicts.pop_front();
          delta--;
          if (rsp.denied !== want.denied)
            report("denied", 64'(rsp.denied), 64'(want.denied));
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
          if (rsp.entry_count !== want.entry_count)
            report("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
        end
        rsp_seen++;
      end
    end
    verdicts_owed <= verdicts_owed + delta;
  end

endmodule

// File: verif/tb.sv
// Testbench top for the MAC deny-list table: stimulus, flow control, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_OPS   = 1850;
  localparam int PAUSE_AT    = 900;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int POOL_SIZE   = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  mdlt_pkg::req_item_t req = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  mdlt_pkg::rsp_item_t rsp;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  int                  errors;
  int                  verdicts_owed;
  int                  quiet_cycles = 0;
  bit                  send_burst = 1'b0;
  bit                  rcv_burst = 1'b0;

  logic [mdlt_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];
  mdlt_pkg::req_item_t        directed_ops [$];

  always #5 clk = ~clk;

  mac_deny_list_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  mdlt_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp           (rsp),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .errors        (errors),
    .verdicts_owed (verdicts_owed)
  );

  function automatic logic [mdlt_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[mdlt_pkg::MAC_W-1:0];
  endfunction

  function automatic mdlt_pkg::req_item_t mk_op(input mdlt_pkg::opcode_t op,
                                                input logic [mdlt_pkg::MAC_W-1:0] mac);
    mdlt_pkg::req_item_t it;
    it.opcode = op;
    it.station_mac = mac;
    return it;
  endfunction

  // Mostly add/check/delete on a small address pool so hits, full and not-found all occur.
  function automatic mdlt_pkg::req_item_t random_op();
    mdlt_pkg::req_item_t it;
    int r;
    if ($urandom_range(0, 49) == 0) mac_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_mac();
    r = $urandom_range(0, 99);
    if (r < 40) it.opcode = mdlt_pkg::OP_ADD;
    else if (r < 68) it.opcode = mdlt_pkg::OP_CHECK;
    else if (r < 88) it.opcode = mdlt_pkg::OP_DELETE;
    else if (r < 90) it.opcode = mdlt_pkg::OP_CLEAR;
    else it.opcode = mdlt_pkg::opcode_t'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 8) it.station_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    else it.station_mac = rand_mac();
    return it;
  endfunction

  task automatic offer(input mdlt_pkg::req_item_t it);
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Result side: random stall per item, one long hold-off to back the block up.
  initial begin : drain
    int wait_n;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
      else wait_n = rcv_burst ? 0 : $urandom_range(0, 7);
      if (wait_n > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      taken++;
      if (taken % 150 == 0) rcv_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stim
    int gap;
    mdlt_pkg::req_item_t it;
    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();

    // empty table, edge addresses, fill to full, duplicate, lowest free slot, clear
    directed_ops.push_back(mk_op(mdlt_pkg::OP_CHECK, '0));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_DELETE, '0));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, '0));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, '1));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, '0));
    for (int k = 1; k <= 14; k++) directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, 48'd1 << k));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, 48'h5555_5555_5555));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_CHECK, '1));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_DELETE, '0));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_ADD, 48'hAAAA_AAAA_AAAA));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_CLEAR, '1));
    directed_ops.push_back(mk_op(mdlt_pkg::OP_CHECK, '1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < TOTAL_OPS; n++) begin
      it = (n < directed_ops.size()) ? directed_ops[n] : random_op();
      offer(it);
      if (n % 150 == 149) send_burst = ($urandom_range(0, 2) == 0);
      if (n == TOTAL_OPS - 1) begin
        req_valid <= 1'b0;
      end else if (n == PAUSE_AT) begin
        // hold until the block has drained completely
        req_valid <= 1'b0;
        do @(posedge clk); while (verdicts_owed != 0);
      end else begin
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    do @(posedge clk); while (verdicts_owed != 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: mac_deny_list_table.f
design/mdlt_pkg.sv
design/mdlt_ram.sv
design/mac_deny_list_table.sv
verif/mdlt_checker.sv
verif/tb.sv
